// ----- rtl/core/triangle_nco_with_vibrato_top_macros.svh -----
// Assertion macros used by the triangle oscillator top level
`ifndef TRIANGLE_NCO_WITH_VIBRATO_TOP_MACROS_SVH
`define TRIANGLE_NCO_WITH_VIBRATO_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TNV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TNV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tnv_pkg.sv -----
// Shared types and constants for the triangle oscillator with vibrato
`default_nettype none

package tnv_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP      = 2'd2;

	// quarter-wave sine polynomial coefficients, Q15
	localparam logic [31:0] POLY_A = 32'd51472;
	localparam logic [31:0] POLY_B = 32'd21024;
	localparam logic [31:0] POLY_C = 32'd2320;

	// largest sine magnitude, Q15
	localparam logic [31:0] SINE_MAX = 32'd32767;

	// vibrato sequencer steps
	typedef enum logic [2:0] {
		VS_IDLE,
		VS_X2,
		VS_T1,
		VS_T2,
		VS_S,
		VS_M,
		VS_D,
		VS_UPD
	} vib_state_t;

	// sequencer status towards the top level
	typedef struct packed {
		logic busy;
		logic done;
	} vib_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/triangle_nco_with_vibrato_top.sv -----
// Top level: triangle oscillator with vibrato mixed into an audio stream
// Usage:
// Input words (base_sample, last_channel) arrive on in_valid/in_stall, one per
// channel sample. Each word is mixed with the triangle at the current carrier
// phase and saturated; the result word (mixed_sample, clipped) appears on
// out_valid/out_stall in the cycle after acceptance, held in an output register.
// A word without last_channel needs no phase update, so such words stream at one per
// cycle while in_stall is low. A word with last_channel starts the phase update: the shared
// multiplier runs six products (sine polynomial, depth scaling, step scaling)
// and an update step, and in_stall stays high until that update step is done.
// When the receiver stalls with a result waiting, in_stall rises until the
// output register drains. Configuration writes (cfg_we, cfg_index, cfg_wdata)
// take effect at once and are to be made only while the block is idle; the
// block itself does not enforce it. Reset clears the configuration registers,
// both phases and the output valid.
`default_nettype none

module triangle_nco_with_vibrato_top #(
	parameter int SINE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS    = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tnv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]  base_sample,
	input  wire logic                           last_channel,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]       mixed_sample,
	output logic                                clipped
);

	logic [31:0] phase_step_q;
	logic [15:0] vibrato_depth_q;
	logic [31:0] lfo_step_q;
	logic [31:0] carrier_q;
	logic [31:0] lfo_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mixed_q;
	logic                          clipped_q;

	logic                          in_accept;
	tnv_pkg::vib_stat_t            vib_stat;
	logic [31:0]                   vib_inc;

	logic [61:0]                   ramp_wide_w;
	logic [SAMPLE_BITS-2:0]        ramp_w;
	logic [SAMPLE_BITS-1:0]        tri_mag_w;
	logic signed [SAMPLE_BITS:0]   tri_w;
	logic signed [SAMPLE_BITS+1:0] sum_w;
	logic                          ovf_w;
	logic signed [SAMPLE_BITS-1:0] sat_w;

	// handshake
	assign in_stall  = vib_stat.busy || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= '0;
			vibrato_depth_q <= '0;
			lfo_step_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tnv_pkg::REG_PHASE_STEP:    phase_step_q    <= cfg_wdata;
				tnv_pkg::REG_VIBRATO_DEPTH: vibrato_depth_q <= cfg_wdata[15:0];
				tnv_pkg::REG_LFO_STEP:      lfo_step_q      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// vibrato increment unit
	tnv_vib #(
		.SINE_ADDR_BITS(SINE_ADDR_BITS)
	) u_vib (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept && last_channel),
		.lfo_phase (lfo_q),
		.depth     (vibrato_depth_q),
		.step      (phase_step_q),
		.stat      (vib_stat),
		.inc       (vib_inc)
	);

	// phase accumulators, advanced once per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			lfo_q     <= '0;
		end else if (vib_stat.done) begin
			carrier_q <= carrier_q + vib_inc;
			lfo_q     <= lfo_q + lfo_step_q;
		end
	end

	// triangle from the quadrant and the in-quadrant fraction
	assign ramp_wide_w = {32'd0, carrier_q[29:0]} << (SAMPLE_BITS - 1);
	assign ramp_w      = ramp_wide_w[30 +: SAMPLE_BITS-1];
	assign tri_mag_w   = carrier_q[30]
		? ({1'b1, {(SAMPLE_BITS-1){1'b0}}} - {1'b0, ramp_w})
		: {1'b0, ramp_w};
	assign tri_w = carrier_q[31] ? -$signed({1'b0, tri_mag_w}) : $signed({1'b0, tri_mag_w});

	// mix and saturate
	assign sum_w = {{2{base_sample[SAMPLE_BITS-1]}}, base_sample}
		+ {tri_w[SAMPLE_BITS], tri_w};
	assign ovf_w = !((sum_w[SAMPLE_BITS+1:SAMPLE_BITS-1] == '0)
		|| (sum_w[SAMPLE_BITS+1:SAMPLE_BITS-1] == '1));
	assign sat_w = sum_w[SAMPLE_BITS+1]
		? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
		: $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mixed_q   <= ovf_w ? sat_w : sum_w[SAMPLE_BITS-1:0];
			clipped_q <= ovf_w;
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign clipped      = clipped_q;

	// checks
`include "triangle_nco_with_vibrato_top_macros.svh"

	`TNV_ASSERT_NEXT(a_frame_starts_update, in_accept && last_channel, vib_stat.busy, "no update")
	`TNV_ASSERT_NEXT(a_phase_hold, !vib_stat.done, $stable(carrier_q) && $stable(lfo_q), "phase moved")
	`TNV_ASSERT_NEXT(a_result_valid, in_accept, out_valid_q, "accepted word gave no result")

endmodule

`default_nettype wire

// ----- rtl/core/tnv_vib.sv -----
// Vibrato increment unit: sine polynomial and frequency scaling on one shared multiplier
`default_nettype none

module tnv_vib #(
	parameter int SINE_ADDR_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [31:0]       lfo_phase,
	input  wire logic [15:0]       depth,
	input  wire logic [31:0]       step,
	output tnv_pkg::vib_stat_t     stat,
	output logic [31:0]            inc
);

	localparam int POS_W   = SINE_ADDR_BITS - 2;
	localparam int X_SHIFT = 17 - SINE_ADDR_BITS;

	tnv_pkg::vib_state_t state_q, state_d;

	logic [SINE_ADDR_BITS-1:0] addr_w;
	logic [POS_W-1:0]          pos_w;
	logic [15:0]               x_lin_w;
	logic [15:0]               x_w;
	logic [14:0]               s_clamp_w;
	logic [31:0]               mul_a;
	logic [31:0]               mul_b;
	logic [63:0]               prod_w;

	logic [15:0] x_q;
	logic [16:0] x2_q;
	logic [31:0] acc_q;
	logic        neg_q;

	// sine argument in Q15, mirrored in the odd quadrants
	assign addr_w  = lfo_phase[31 -: SINE_ADDR_BITS];
	assign pos_w   = addr_w[POS_W-1:0];
	assign x_lin_w = 16'(pos_w) << X_SHIFT;
	assign x_w     = addr_w[POS_W] ? 16'(17'd65536 / 17'd2 - 17'(x_lin_w)) : x_lin_w;

	// sine magnitude clamped below one
	assign s_clamp_w = (acc_q > tnv_pkg::SINE_MAX) ? 15'h7FFF : acc_q[14:0];

	// the shared multiplier
	assign prod_w = 64'(mul_a) * 64'(mul_b);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnv_pkg::VS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and multiplier operand selection
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			tnv_pkg::VS_IDLE: begin
				if (start) begin
					state_d = tnv_pkg::VS_X2;
				end
			end
			tnv_pkg::VS_X2: begin
				mul_a   = 32'(x_q);
				mul_b   = 32'(x_q);
				state_d = tnv_pkg::VS_T1;
			end
			tnv_pkg::VS_T1: begin
				mul_a   = tnv_pkg::POLY_C;
				mul_b   = 32'(x2_q);
				state_d = tnv_pkg::VS_T2;
			end
			tnv_pkg::VS_T2: begin
				mul_a   = tnv_pkg::POLY_B - acc_q;
				mul_b   = 32'(x2_q);
				state_d = tnv_pkg::VS_S;
			end
			tnv_pkg::VS_S: begin
				mul_a   = tnv_pkg::POLY_A - acc_q;
				mul_b   = 32'(x_q);
				state_d = tnv_pkg::VS_M;
			end
			tnv_pkg::VS_M: begin
				mul_a   = 32'(depth);
				mul_b   = 32'(s_clamp_w);
				state_d = tnv_pkg::VS_D;
			end
			tnv_pkg::VS_D: begin
				mul_a   = step;
				mul_b   = acc_q;
				state_d = tnv_pkg::VS_UPD;
			end
			tnv_pkg::VS_UPD: begin
				state_d = tnv_pkg::VS_IDLE;
			end
			default: begin
				state_d = tnv_pkg::VS_IDLE;
			end
		endcase
	end

	// datapath registers, loaded per step
	always_ff @(posedge clk) begin
		case (state_q)
			tnv_pkg::VS_IDLE: begin
				if (start) begin
					x_q   <= x_w;
					neg_q <= addr_w[SINE_ADDR_BITS-1];
				end
			end
			tnv_pkg::VS_X2: begin
				x2_q <= prod_w[31:15];
			end
			tnv_pkg::VS_T1, tnv_pkg::VS_T2, tnv_pkg::VS_S: begin
				acc_q <= prod_w[46:15];
			end
			tnv_pkg::VS_M: begin
				acc_q <= prod_w[31:0];
			end
			tnv_pkg::VS_D: begin
				acc_q <= prod_w[61:30];
			end
			default: begin
			end
		endcase
	end

	// carrier increment: step scaled up or down by the modulation
	assign inc = neg_q ? (step - acc_q) : (step + acc_q);

	assign stat.busy = (state_q != tnv_pkg::VS_IDLE);
	assign stat.done = (state_q == tnv_pkg::VS_UPD);

endmodule

`default_nettype wire
